// ----- src/srr_pkg.sv -----
package srr_pkg;

	localparam int SEQ_W      = 4;
	localparam int DATA_W     = 32;
	localparam int MOD_W      = 5;
	localparam int WIN_W      = 4;
	localparam int MAX_SEQ    = 16;
	localparam int MAX_WINDOW = 8;
	localparam int IDX_W      = $clog2(MAX_SEQ);
	localparam int CNT_W      = WIN_W;

	localparam int IN_TDATA_W  = ((SEQ_W + DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((SEQ_W + DATA_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = MOD_W;

	localparam logic [MOD_W-1:0] SEQ_MODULUS_RST = MOD_W'(16);
	localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = WIN_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEQ_MODULUS = 1'b0,
		CFG_WINDOW_SIZE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK,
		ST_READ,
		ST_DELIV
	} state_t;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

endpackage

// ----- src/srr_payload_ram.sv -----
module srr_payload_ram #(
	parameter int DEPTH = srr_pkg::MAX_SEQ,
	parameter int WIDTH = srr_pkg::DATA_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/selective_repeat_receiver.sv -----
// selective-repeat arq receiver
// input stream: one data packet per transaction; tuser carries checksum_ok,
// tdata carries seq_num (low bits) and payload. corrupted packets, sequence
// numbers at or above the modulus and packets outside both windows are
// absorbed with no output.
// output stream: an acknowledgment (tuser kind 0, ack_num in tdata) for every
// packet in the receive window or in the previous window, then, when the
// packet sits at the window base, the buffered payloads from the base onward
// in order (kind 1, data_out in tdata), up to one window of them. tlast marks
// the final transaction caused by a packet.
// sequencing: an accepted packet's ack is loaded into the output register
// once that register is free; each delivered payload takes a payload ram
// read, then an output. the input is not ready while an acknowledged
// packet's ack and payloads are issued; a dropped packet leaves it ready.
// the output register lets the next packet be accepted while the last result
// waits; a stall on the output side holds the sequencer in place with no loss.
// reset, or any configuration write, puts the window base at zero and drops
// every buffered payload; configuration defaults are modulus 16, window 4.
module selective_repeat_receiver (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [srr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srr_pkg::CFG_DATA_W-1:0]      cfg_data,
	// packet input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [srr_pkg::IN_TDATA_W-1:0]      s_tdata,  // seq_num, payload
	input  logic                                s_tuser,  // checksum_ok
	// result output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [srr_pkg::OUT_TDATA_W-1:0]     m_tdata,  // ack_num, data_out
	output logic                                m_tuser,  // kind
	output logic                                m_tlast
);

	localparam int SEQ_W  = srr_pkg::SEQ_W;
	localparam int DATA_W = srr_pkg::DATA_W;
	localparam int MOD_W  = srr_pkg::MOD_W;
	localparam int WIN_W  = srr_pkg::WIN_W;
	localparam int IDX_W  = srr_pkg::IDX_W;
	localparam int CNT_W  = srr_pkg::CNT_W;

	// configuration registers
	logic [MOD_W-1:0] seq_modulus_q;
	logic [WIN_W-1:0] window_size_q;

	// window state
	logic [SEQ_W-1:0]         base_q;
	logic [srr_pkg::MAX_SEQ-1:0] held_q;

	// packet under work
	logic [SEQ_W-1:0]  seq_q;
	logic [DATA_W-1:0] payload_q;
	logic              in_win_q;
	logic              at_base_q;
	logic [CNT_W-1:0]  cnt_q;

	srr_pkg::state_t state_q, state_d;

	// effective modulus and window
	logic [MOD_W-1:0] mod_eff;
	logic [WIN_W-1:0] lim;
	logic [WIN_W-1:0] win_eff;

	always_comb begin
		if (seq_modulus_q < MOD_W'(2)) begin
			mod_eff = MOD_W'(2);
		end else if (seq_modulus_q > MOD_W'(srr_pkg::MAX_SEQ)) begin
			mod_eff = MOD_W'(srr_pkg::MAX_SEQ);
		end else begin
			mod_eff = seq_modulus_q;
		end
		lim = mod_eff[MOD_W-1:1];
		if (lim > WIN_W'(srr_pkg::MAX_WINDOW)) begin
			lim = WIN_W'(srr_pkg::MAX_WINDOW);
		end
		if (lim == '0) begin
			lim = WIN_W'(1);
		end
		if (window_size_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (window_size_q > lim) begin
			win_eff = lim;
		end else begin
			win_eff = window_size_q;
		end
	end

	// classify the incoming packet
	logic [SEQ_W-1:0]  in_seq;
	logic [DATA_W-1:0] in_payload;
	logic [MOD_W-1:0]  seq_ext, base_ext, seq_dist;
	logic              in_range, in_win, in_prev;

	assign in_seq     = s_tdata[SEQ_W-1:0];
	assign in_payload = s_tdata[SEQ_W+DATA_W-1:SEQ_W];
	assign seq_ext    = MOD_W'(in_seq);
	assign base_ext   = MOD_W'(base_q);
	assign in_range   = s_tuser && (seq_ext < mod_eff);

	always_comb begin
		if (seq_ext >= base_ext) begin
			seq_dist = seq_ext - base_ext;
		end else begin
			seq_dist = seq_ext + mod_eff - base_ext;
		end
	end

	assign in_win  = in_range && (seq_dist < MOD_W'(win_eff));
	assign in_prev = in_range && (seq_dist >= mod_eff - MOD_W'(win_eff));

	// next base, wrapping at the modulus
	logic [MOD_W-1:0] base_inc;
	logic [SEQ_W-1:0] base_next;

	assign base_inc  = base_ext + MOD_W'(1);
	assign base_next = (base_inc == mod_eff) ? '0 : SEQ_W'(base_inc);

	// payload ram
	logic              ram_wr, ram_rd;
	logic [DATA_W-1:0] ram_rdata;

	srr_payload_ram #(
		.DEPTH(srr_pkg::MAX_SEQ),
		.WIDTH(DATA_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (IDX_W'(seq_q)),
		.wr_data (payload_q),
		.rd_en   (ram_rd),
		.rd_addr (IDX_W'(base_q)),
		.rd_data (ram_rdata)
	);

	// sequencer
	logic             out_free;
	logic             accept;
	logic             out_load;
	logic             out_kind;
	logic [SEQ_W-1:0] out_ack;
	logic [DATA_W-1:0] out_data;
	logic             out_last;
	logic             set_held;
	logic             deliver;
	logic             run_end;

	assign out_free = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign run_end  = (cnt_q + CNT_W'(1) == CNT_W'(win_eff)) || !held_q[IDX_W'(base_next)];

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		out_kind = srr_pkg::KIND_ACK;
		out_ack  = seq_q;
		out_data = '0;
		out_last = 1'b0;
		ram_wr   = 1'b0;
		ram_rd   = 1'b0;
		set_held = 1'b0;
		deliver  = 1'b0;
		unique case (state_q)
			srr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (in_win || in_prev)) begin
					state_d = srr_pkg::ST_ACK;
				end
			end
			srr_pkg::ST_ACK: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind = srr_pkg::KIND_ACK;
					out_ack  = seq_q;
					out_last = !at_base_q;
					if (in_win_q && !held_q[IDX_W'(seq_q)]) begin
						ram_wr   = 1'b1;
						set_held = 1'b1;
					end
					state_d = at_base_q ? srr_pkg::ST_READ : srr_pkg::ST_IDLE;
				end
			end
			srr_pkg::ST_READ: begin
				ram_rd  = 1'b1;
				state_d = srr_pkg::ST_DELIV;
			end
			srr_pkg::ST_DELIV: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind = srr_pkg::KIND_DATA;
					out_ack  = '0;
					out_data = ram_rdata;
					out_last = run_end;
					deliver  = 1'b1;
					state_d  = run_end ? srr_pkg::ST_IDLE : srr_pkg::ST_READ;
				end
			end
			default: begin
				state_d = srr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_modulus_q <= srr_pkg::SEQ_MODULUS_RST;
			window_size_q <= srr_pkg::WINDOW_SIZE_RST;
			base_q        <= '0;
			held_q        <= '0;
		end else if (cfg_we) begin
			unique case (srr_pkg::cfg_reg_t'(cfg_index))
				srr_pkg::CFG_SEQ_MODULUS: seq_modulus_q <= cfg_data;
				srr_pkg::CFG_WINDOW_SIZE: window_size_q <= WIN_W'(cfg_data);
				default: ;
			endcase
			base_q <= '0;
			held_q <= '0;
		end else begin
			if (set_held) begin
				held_q[IDX_W'(seq_q)] <= 1'b1;
			end
			if (deliver) begin
				held_q[IDX_W'(base_q)] <= 1'b0;
				base_q <= base_next;
			end
		end
	end

	// accepted packet
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q     <= in_seq;
			payload_q <= in_payload;
			in_win_q  <= in_win;
			at_base_q <= in_win && (in_seq == base_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == srr_pkg::ST_ACK) begin
			cnt_q <= '0;
		end else if (deliver) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= srr_pkg::OUT_TDATA_W'({out_data, out_ack});
			m_tuser <= out_kind;
			m_tlast <= out_last;
		end
	end

endmodule

// ----- test/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEQ_W       = srr_pkg::SEQ_W;
	localparam int DATA_W      = srr_pkg::DATA_W;
	localparam int MOD_W       = srr_pkg::MOD_W;
	localparam int WIN_W       = srr_pkg::WIN_W;
	localparam int MAX_SEQ     = srr_pkg::MAX_SEQ;
	localparam int MAX_WINDOW  = srr_pkg::MAX_WINDOW;
	localparam int IN_TDATA_W  = srr_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = srr_pkg::OUT_TDATA_W;
	localparam int CFG_IDX_W   = srr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = srr_pkg::CFG_DATA_W;

	localparam int SETTLE_CYCLES = 2 + 2 * MAX_WINDOW + 12;

	typedef struct packed {
		logic              kind;
		logic [SEQ_W-1:0]  ack_num;
		logic [DATA_W-1:0] data_out;
		logic              last;
	} arq_out_t;

	typedef struct {
		bit                    is_cfg;
		srr_pkg::cfg_reg_t     reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  ok;
		logic [SEQ_W-1:0]      seq;
		logic [DATA_W-1:0]     pay;
		bit                    typed;
		int                    nres;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // seq_num, payload
	logic                   s_tuser = 1'b0; // checksum_ok
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // ack_num, data_out
	logic                   m_tuser;        // kind
	logic                   m_tlast;

	// typed expectation for the packet currently offered
	bit row_typed = 1'b0;
	int row_nres = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int n_packets = 0;
	int n_results = 0;
	int n_writes = 0;

	// receiver state mirror
	logic [MOD_W-1:0]  mod_reg = srr_pkg::SEQ_MODULUS_RST;
	logic [WIN_W-1:0]  win_reg = srr_pkg::WINDOW_SIZE_RST;
	logic [SEQ_W-1:0]  win_base = '0;
	bit                held_flag [MAX_SEQ];
	logic [DATA_W-1:0] held_data [MAX_SEQ];
	arq_out_t          arq_out_q [$];

	stim_row_t dir_rows [26] = '{
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b0, 4'd0,  32'hFFFF_FFFF, 1'b1, 0}, // corrupted
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd1,  32'h0000_0000, 1'b1, 1},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd3,  32'hA5A5_A5A5, 1'b1, 1},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd1,  32'h1234_5678, 1'b1, 1}, // duplicate
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd0,  32'hFFFF_FFFF, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd15, 32'h5A5A_5A5A, 1'b0, 0}, // prev window
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd8,  32'h0F0F_0F0F, 1'b0, 0}, // outside both
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd5,  32'hDEAD_BEEF, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd4,  32'h8000_0001, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd2,  32'h7FFF_FFFE, 1'b0, 0}, // full window
		'{1'b1, srr_pkg::CFG_SEQ_MODULUS, 5'd2,  1'b0, 4'd0,  32'h0,         1'b0, 0},
		'{1'b1, srr_pkg::CFG_WINDOW_SIZE, 5'd1,  1'b0, 4'd0,  32'h0,         1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd2,  32'h3C3C_3C3C, 1'b1, 0}, // above modulus
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd0,  32'hC3C3_C3C3, 1'b1, 2},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd0,  32'h0000_0000, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd1,  32'hFFFF_0000, 1'b0, 0},
		'{1'b1, srr_pkg::CFG_SEQ_MODULUS, 5'd16, 1'b0, 4'd0,  32'h0,         1'b0, 0},
		'{1'b1, srr_pkg::CFG_WINDOW_SIZE, 5'd8,  1'b0, 4'd0,  32'h0,         1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd1,  32'h1111_1111, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd2,  32'h2222_2222, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd3,  32'h3333_3333, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd4,  32'h4444_4444, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd5,  32'h5555_5555, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd6,  32'h6666_6666, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd7,  32'h7777_7777, 1'b0, 0},
		'{1'b0, srr_pkg::CFG_SEQ_MODULUS, 5'd0,  1'b1, 4'd0,  32'h8888_8888, 1'b0, 0}  // releases eight
	};

	// settings for the random phases, two per phase; out-of-range values saturate
	logic [CFG_DATA_W-1:0] set_mod [6] = '{5'd7, 5'd0, 5'd31, 5'd9, 5'd12, 5'd16};
	logic [CFG_DATA_W-1:0] set_win [6] = '{5'd3, 5'd0, 5'd15, 5'd2, 5'd6,  5'd8};
	int phase_send [3] = '{31, 77, 0};
	int phase_recv [3] = '{77, 31, 0};

	selective_repeat_receiver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic int clamp_modulus();
		int m;
		m = mod_reg;
		if (m < 2)
			m = 2;
		if (m > MAX_SEQ)
			m = MAX_SEQ;
		return m;
	endfunction

	function automatic int clamp_window(int m);
		int lim;
		int w;
		lim = m / 2;
		if (lim > MAX_WINDOW)
			lim = MAX_WINDOW;
		if (lim < 1)
			lim = 1;
		w = win_reg;
		if (w < 1)
			w = 1;
		if (w > lim)
			w = lim;
		return w;
	endfunction

	// acknowledgment, buffering and in-order release for one packet
	function automatic void arq_receive(logic ok, logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] pay);
		int m;
		int w;
		int base;
		int seq_dist;
		int first;
		int i;
		arq_out_t tmp;
		if (!ok)
			return;
		m = clamp_modulus();
		w = clamp_window(m);
		if (seq >= m)
			return;
		base = win_base % m;
		seq_dist = (int'(seq) + m - base) % m;
		first = arq_out_q.size();
		if (seq_dist < w) begin
			arq_out_q.push_back('{srr_pkg::KIND_ACK, seq, DATA_W'(0), 1'b0});
			if (!held_flag[seq]) begin
				held_flag[seq] = 1'b1;
				held_data[seq] = pay;
			end
			if (seq == base) begin
				for (i = 0; i < w && held_flag[base]; i++) begin
					arq_out_q.push_back('{srr_pkg::KIND_DATA, SEQ_W'(0), held_data[base], 1'b0});
					held_flag[base] = 1'b0;
					base = (base + 1) % m;
				end
				win_base = SEQ_W'(base);
			end
		end else if (seq_dist >= m - w) begin
			arq_out_q.push_back('{srr_pkg::KIND_ACK, seq, DATA_W'(0), 1'b0});
		end
		if (arq_out_q.size() > first) begin
			tmp = arq_out_q.pop_back();
			tmp.last = 1'b1;
			arq_out_q.push_back(tmp);
		end
	endfunction

	always @(posedge clk) begin : monitor
		arq_out_t got;
		arq_out_t want;
		int n_before;
		if (arst_n) begin
			if (cfg_we) begin
				case (srr_pkg::cfg_reg_t'(cfg_index))
					srr_pkg::CFG_SEQ_MODULUS: mod_reg = cfg_data;
					srr_pkg::CFG_WINDOW_SIZE: win_reg = cfg_data[WIN_W-1:0];
					default: ;
				endcase
				win_base = '0;
				foreach (held_flag[i])
					held_flag[i] = 1'b0;
			end
			if (s_tvalid && s_tready) begin
				n_before = arq_out_q.size();
				arq_receive(s_tuser, s_tdata[SEQ_W-1:0], s_tdata[SEQ_W +: DATA_W]);
				n_packets++;
				if (row_typed) begin
					// directed rows with an obvious answer replace the prediction
					while (arq_out_q.size() > n_before)
						void'(arq_out_q.pop_back());
					if (row_nres > 0)
						arq_out_q.push_back('{srr_pkg::KIND_ACK, s_tdata[SEQ_W-1:0],
							DATA_W'(0), row_nres == 1});
					if (row_nres > 1)
						arq_out_q.push_back('{srr_pkg::KIND_DATA, SEQ_W'(0),
							s_tdata[SEQ_W +: DATA_W], 1'b1});
				end
			end
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.ack_num = m_tdata[SEQ_W-1:0];
				got.data_out = m_tdata[SEQ_W +: DATA_W];
				got.last = m_tlast;
				n_results++;
				if (arq_out_q.size() == 0) begin
					$error("unexpected transaction: kind %0d ack_num %0d data_out %h last %0d",
						got.kind, got.ack_num, got.data_out, got.last);
					errors++;
				end else begin
					want = arq_out_q.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						errors++;
					end
					if (got.ack_num !== want.ack_num) begin
						$error("ack_num: expected %0d, got %0d", want.ack_num, got.ack_num);
						errors++;
					end
					if (got.data_out !== want.data_out) begin
						$error("data_out: expected %h, got %h", want.data_out, got.data_out);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, got.last);
						errors++;
					end
				end
			end
		end
	end

	// called and returning on a falling edge
	task automatic send_packet(input logic ok, input logic [SEQ_W-1:0] seq,
		input logic [DATA_W-1:0] pay, input bit typed, input int nres);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= ok;
		s_tdata <= IN_TDATA_W'({pay, seq});
		row_typed <= typed;
		row_nres <= nres;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// all results in, plus time for a packet that releases nothing
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (arq_out_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input srr_pkg::cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		n_writes++;
	endtask

	// mostly in-window packets with random content, some stale, corrupted or stray
	task automatic run_random(input int n_good);
		int good;
		int m;
		int w;
		int base;
		int pick;
		logic ok;
		logic [SEQ_W-1:0] seq;
		good = 0;
		while (good < n_good) begin
			m = clamp_modulus();
			w = clamp_window(m);
			base = win_base % m;
			pick = $urandom_range(99);
			ok = 1'b1;
			if (pick < 70) begin
				seq = SEQ_W'((base + int'($urandom_range(w - 1))) % m);
				good++;
			end else if (pick < 80) begin
				seq = SEQ_W'((base + m - 1 - int'($urandom_range(w - 1))) % m);
				good++;
			end else if (pick < 90) begin
				seq = SEQ_W'($urandom_range(MAX_SEQ - 1));
				ok = 1'b0;
			end else begin
				seq = SEQ_W'($urandom_range(MAX_SEQ - 1));
			end
			send_packet(ok, seq, $urandom, 1'b0, 0);
		end
	endtask

	initial begin : stimulus
		int p;
		int k;
		send_idle_pct = phase_send[0];
		recv_idle_pct = phase_recv[0];
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg) begin
				wait_idle();
				write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
			end else begin
				send_packet(dir_rows[r].ok, dir_rows[r].seq, dir_rows[r].pay,
					dir_rows[r].typed, dir_rows[r].nres);
			end
		end
		for (p = 0; p < 3; p++) begin
			send_idle_pct = phase_send[p];
			recv_idle_pct = phase_recv[p];
			for (k = 2 * p; k < 2 * p + 2; k++) begin
				wait_idle();
				write_reg(srr_pkg::CFG_SEQ_MODULUS, set_mod[k]);
				write_reg(srr_pkg::CFG_WINDOW_SIZE, set_win[k]);
				run_random(13);
			end
		end
		wait_idle();
		$display("%0d packets accepted, %0d output transactions checked", n_packets, n_results);
		$display("%0d register writes, moduli 2..16, windows 1..8, three idle mixes", n_writes);
		if (errors == 0)
			$display("PASS selective_repeat_receiver");
		else
			$display("FAIL selective_repeat_receiver");
		$finish;
	end

	initial begin : watchdog
		#2ms;
		$display("FAIL selective_repeat_receiver");
		$finish;
	end

endmodule
